// ----- rtl/core/fpsp_pkg.sv -----
`timescale 1ns / 1ps

package fpsp_pkg;

    localparam int IN_W        = 32;
    localparam int OUT_W       = 32;
    localparam int THR_W       = 16;
    localparam int QUEUE_DEPTH = 4;

    // divide by three, sixteen bits per step
    localparam int CHUNK_W    = 16;
    localparam int RECIP_W    = 19;
    localparam int DIV3_SHIFT = 20;
    localparam logic [RECIP_W-1:0] DIV3_RECIP = 19'd349526;

    typedef enum logic [1:0] {
        K_NONE,
        K_PASS,
        K_CORR
    } t_kind;

    typedef enum logic [1:0] {
        S_EMPTY,
        S_ONE,
        S_TWO
    } t_seen;

    typedef struct packed {
        t_kind kind;
        logic  last;
    } t_ctl;

endpackage

// ----- rtl/core/fpsp_in_if.sv -----
`timescale 1ns / 1ps

interface fpsp_in_if;
    logic                     valid;
    logic                     ready;
    logic [fpsp_pkg::IN_W-1:0] time_req;
    logic                     last;

    modport source (output valid, output time_req, output last, input ready);
    modport sink (input valid, input time_req, input last, output ready);
endinterface

// ----- rtl/core/fpsp_out_if.sv -----
`timescale 1ns / 1ps

interface fpsp_out_if;
    logic                      valid;
    logic                      ready;
    logic [fpsp_pkg::OUT_W-1:0] time_res;
    logic                      last_res;

    modport source (output valid, output time_res, output last_res, input ready);
    modport sink (input valid, input time_res, input last_res, output ready);
endinterface

// ----- rtl/core/fpsp_front.sv -----
`timescale 1ns / 1ps

module fpsp_front #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [fpsp_pkg::IN_W-1:0]  i_time_req,
    input  logic                       i_last,
    input  logic                       i_full,
    output logic                       o_push,
    output fpsp_pkg::t_ctl             o_ctl,
    output logic [TIME_WIDTH-1:0]      o_t1,
    output logic [TIME_WIDTH-1:0]      o_t2,
    output logic [TIME_WIDTH-1:0]      o_g01,
    output logic [TIME_WIDTH-1:0]      o_g12
);
    import fpsp_pkg::*;

    t_seen                 r_seen;
    t_seen                 n_seen;
    logic [TIME_WIDTH-1:0] r_newer;
    logic [TIME_WIDTH-1:0] r_gap;
    logic [TIME_WIDTH-1:0] c_t;
    logic [TIME_WIDTH-1:0] c_gap;
    logic                  c_acc;

    assign o_ready = !i_full;
    assign c_acc   = i_valid && !i_full;
    assign c_t     = TIME_WIDTH'(i_time_req);
    assign c_gap   = c_t - r_newer;

    always_comb begin
        n_seen = r_seen;
        if (c_acc) begin
            unique case (r_seen)
                S_EMPTY: begin
                    n_seen = i_last ? S_EMPTY : S_ONE;
                end
                S_ONE, S_TWO: begin
                    n_seen = i_last ? S_EMPTY : S_TWO;
                end
                default: begin
                    n_seen = S_EMPTY;
                end
            endcase
        end
    end

    always_comb begin
        o_push     = c_acc && ((r_seen != S_EMPTY) || i_last);
        o_ctl.last = i_last;
        unique case (r_seen)
            S_ONE: begin
                o_ctl.kind = K_PASS;
            end
            S_TWO: begin
                o_ctl.kind = K_CORR;
            end
            default: begin
                o_ctl.kind = K_NONE;
            end
        endcase
        o_t1  = r_newer;
        o_t2  = c_t;
        o_g01 = r_gap;
        o_g12 = c_gap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= S_EMPTY;
        end else begin
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_acc) begin
            r_newer <= c_t;
            r_gap   <= c_gap;
        end
    end

endmodule

// ----- rtl/core/fpsp_fifo.sv -----
`timescale 1ns / 1ps

module fpsp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_count;

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (AW+1)'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            r_count <= r_count + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + (AW+1)'(1))
        else $error("queue count did not follow push");
`endif

endmodule

// ----- rtl/core/fpsp_back.sv -----
`timescale 1ns / 1ps

module fpsp_back #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_we,
    input  logic [fpsp_pkg::THR_W-1:0]                    i_cfg_wdata,
    input  logic [$bits(fpsp_pkg::t_ctl)+4*TIME_WIDTH-1:0] i_data,
    input  logic                                          i_empty,
    output logic                                          o_pop,
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output logic [fpsp_pkg::OUT_W-1:0]                    o_time_res,
    output logic                                          o_last_res
);
    import fpsp_pkg::*;

    localparam int TW   = TIME_WIDTH;
    localparam int DW   = TW + 1;
    localparam int WW   = TW + 4;
    localparam int VW   = TW + 2;
    localparam int SW   = TW + 1;
    localparam int XW   = CHUNK_W + 2;
    localparam int PRW  = XW + RECIP_W;
    localparam int N_CH = (VW + CHUNK_W - 1) / CHUNK_W;
    localparam int PW   = N_CH * CHUNK_W;
    localparam int DV0  = 4;
    localparam int NS   = DV0 + N_CH + 1;
    localparam int LAST = NS - 1;

    typedef struct packed {
        t_ctl          ctl;
        logic          sgn;
        logic [TW-1:0] t1;
        logic [TW-1:0] t2;
        logic [TW-1:0] lo;
        logic [TW-1:0] hi;
    } t_carry;

    // queue entry
    t_ctl          e_ctl;
    logic [TW-1:0] e_t1;
    logic [TW-1:0] e_t2;
    logic [TW-1:0] e_g01;
    logic [TW-1:0] e_g12;

    logic          c_adv;
    logic          c_fin;
    logic [TW-1:0] c_neg01;
    logic [TW-1:0] c_neg12;
    logic [TW-1:0] c_g12p;
    logic [TW-1:0] c_m01;
    logic [TW-1:0] c_m12;
    logic [TW-1:0] c_lo;
    logic [TW-1:0] c_hi;
    logic [DW-1:0] c_thr;
    logic [DW-1:0] c_d1;
    logic [DW-1:0] c_d2;
    logic          c_sgn;
    logic [DW-1:0] c_m;
    logic [WW-1:0] c_w;
    logic [WW-1:0] c_w5;
    logic [VW-1:0] c_v;

    logic [PW-1:0]      c_vin  [N_CH];
    logic [PW-1:0]      c_qin  [N_CH];
    logic [1:0]         c_rin  [N_CH];
    logic [XW-1:0]      c_x    [N_CH];
    logic [PRW-1:0]     c_prod [N_CH];
    logic [CHUNK_W-1:0] c_qd   [N_CH];
    logic [XW-1:0]      c_rx   [N_CH];
    logic [PW-1:0]      c_qout [N_CH];

    logic [SW-1:0]        c_q;
    logic [SW-1:0]        c_s;
    logic signed [SW-1:0] c_ss;
    logic signed [SW-1:0] c_lo_x;
    logic signed [SW-1:0] c_hi_x;
    logic                 c_blo;
    logic                 c_bhi;
    logic                 c_inv;
    logic [TW-1:0]        c_sum_s;
    logic [TW-1:0]        c_sum_lo;
    logic [TW-1:0]        c_sum_hi;
    logic [TW-1:0]        c_res;

    logic [THR_W-1:0] r_thr;
    logic             r_vld [NS];
    t_carry           r_cr  [NS];
    logic             r_n01;
    logic             r_n12;
    logic [TW-1:0]    r_m01;
    logic [TW-1:0]    r_m12;
    logic [DW-1:0]    r_d1;
    logic [DW-1:0]    r_d2;
    logic [DW-1:0]    r_m;
    logic [VW-1:0]    r_v;
    logic [PW-1:0]    r_dv [N_CH];
    logic [PW-1:0]    r_dq [N_CH];
    logic [1:0]       r_dr [N_CH];
    logic [SW-1:0]    r_s;

    logic                r_e_valid;
    logic                r_phase;
    t_ctl                r_e_ctl;
    logic [OUT_W-1:0]    r_e_res;
    logic [OUT_W-1:0]    r_e_t2;

    assign {e_ctl, e_t1, e_t2, e_g01, e_g12} = i_data;

    // gap magnitudes and clamp bounds
    always_comb begin
        c_neg01 = ~e_g01 + TW'(1);
        c_neg12 = ~e_g12 + TW'(1);
        c_g12p  = e_g12 + TW'(1);
        c_m01   = e_g01[TW-1] ? c_neg01 : e_g01;
        c_m12   = e_g12[TW-1] ? c_neg12 : e_g12;
        c_lo    = e_g01[TW-1] ? {1'b0, c_neg01[TW-1:1]}
                              : ~{1'b0, e_g01[TW-1:1]} + TW'(1);
        c_hi    = e_g12[TW-1] ? {c_g12p[TW-1], c_g12p[TW-1:1]}
                              : {1'b0, e_g12[TW-1:1]};
    end

    // push amounts
    always_comb begin
        c_thr = DW'(r_thr);
        if (r_n01) begin
            c_d1 = c_thr + DW'(r_m01);
        end else begin
            c_d1 = (c_thr > DW'(r_m01)) ? c_thr - DW'(r_m01) : '0;
        end
        if (r_n12) begin
            c_d2 = c_thr + DW'(r_m12);
        end else begin
            c_d2 = (c_thr > DW'(r_m12)) ? c_thr - DW'(r_m12) : '0;
        end
    end

    // |d2 - d1| and five quarters of it
    always_comb begin
        c_sgn = r_d2 < r_d1;
        c_m   = c_sgn ? r_d1 - r_d2 : r_d2 - r_d1;
        c_w   = WW'(r_m);
        c_w5  = c_w + (c_w << 2);
        c_v   = c_w5[WW-1:2];
    end

    // divide by three, msb chunk first
    for (genvar k = 0; k < N_CH; k++) begin : g_div
        if (k == 0) begin : g_first
            assign c_vin[k] = PW'(r_v);
            assign c_qin[k] = '0;
            assign c_rin[k] = 2'b00;
        end else begin : g_next
            assign c_vin[k] = r_dv[k-1];
            assign c_qin[k] = r_dq[k-1];
            assign c_rin[k] = r_dr[k-1];
        end
        assign c_x[k]    = {c_rin[k], c_vin[k][PW-1-CHUNK_W*k -: CHUNK_W]};
        assign c_prod[k] = PRW'(c_x[k]) * PRW'(DIV3_RECIP);
        assign c_qd[k]   = c_prod[k][DIV3_SHIFT +: CHUNK_W];
        assign c_rx[k]   = c_x[k] - (XW'({c_qd[k], 1'b0}) + XW'(c_qd[k]));
        assign c_qout[k] = c_qin[k] | (PW'(c_qd[k]) << (PW - CHUNK_W * (k + 1)));
    end

    // signed shift
    always_comb begin
        c_q = SW'(r_dq[N_CH-1][TW-1:0]);
        c_s = r_cr[DV0+N_CH-1].sgn ? ~c_q + SW'(1) : c_q;
    end

    // clamp and apply
    always_comb begin
        c_ss     = $signed(r_s);
        c_lo_x   = SW'($signed(r_cr[LAST].lo));
        c_hi_x   = SW'($signed(r_cr[LAST].hi));
        c_blo    = c_ss < c_lo_x;
        c_bhi    = c_ss > c_hi_x;
        c_inv    = c_lo_x > c_hi_x;
        c_sum_s  = r_cr[LAST].t1 + r_s[TW-1:0];
        c_sum_lo = r_cr[LAST].t1 + r_cr[LAST].lo;
        c_sum_hi = r_cr[LAST].t1 + r_cr[LAST].hi;
        case (r_cr[LAST].ctl.kind)
            K_CORR: begin
                if (c_blo) begin
                    c_res = c_inv ? c_sum_hi : c_sum_lo;
                end else begin
                    c_res = c_bhi ? c_sum_hi : c_sum_s;
                end
            end
            default: begin
                c_res = r_cr[LAST].t1;
            end
        endcase
    end

    assign c_fin = (r_e_ctl.kind == K_NONE) || r_phase || !r_e_ctl.last;
    assign c_adv = !r_e_valid || (i_ready && c_fin);
    assign o_pop = c_adv && !i_empty;

    assign o_valid    = r_e_valid;
    assign o_last_res = (r_e_ctl.kind == K_NONE) || r_phase;
    assign o_time_res = o_last_res ? r_e_t2 : r_e_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= '0;
            r_e_valid <= 1'b0;
            r_phase   <= 1'b0;
            for (int i = 0; i < NS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (c_adv) begin
                r_vld[0] <= !i_empty;
                for (int i = 1; i < NS; i++) begin
                    r_vld[i] <= r_vld[i-1];
                end
                r_e_valid <= r_vld[LAST];
                r_phase   <= 1'b0;
            end else if (i_ready) begin
                r_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_adv) begin
            r_cr[0] <= '{ctl: e_ctl, sgn: 1'b0, t1: e_t1, t2: e_t2, lo: c_lo, hi: c_hi};
            for (int i = 1; i < NS; i++) begin
                if (i == 2) begin
                    r_cr[i] <= '{ctl: r_cr[i-1].ctl, sgn: c_sgn, t1: r_cr[i-1].t1,
                                 t2: r_cr[i-1].t2, lo: r_cr[i-1].lo, hi: r_cr[i-1].hi};
                end else begin
                    r_cr[i] <= r_cr[i-1];
                end
            end
            r_n01 <= e_g01[TW-1];
            r_n12 <= e_g12[TW-1];
            r_m01 <= c_m01;
            r_m12 <= c_m12;
            r_d1  <= c_d1;
            r_d2  <= c_d2;
            r_m   <= c_m;
            r_v   <= c_v;
            for (int k = 0; k < N_CH; k++) begin
                r_dv[k] <= c_vin[k];
                r_dq[k] <= c_qout[k];
                r_dr[k] <= c_rx[k][1:0];
            end
            r_s     <= c_s;
            r_e_ctl <= r_cr[LAST].ctl;
            r_e_res <= OUT_W'(c_res);
            r_e_t2  <= OUT_W'(r_cr[LAST].t2);
        end
    end

`ifndef SYNTH
    a_second_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> r_e_valid && r_e_ctl.last && (r_e_ctl.kind != K_NONE))
        else $error("second beat without a closing item");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_adv && r_vld[LAST]) |=> r_e_valid)
        else $error("pipeline item lost at output register");

    a_lone_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_valid && (r_e_ctl.kind == K_NONE)) |-> r_e_ctl.last)
        else $error("pass-only entry without track end");
`endif

endmodule

// ----- rtl/core/flux_peak_shift_postcomp.sv -----
// Peak-shift post-compensation of flux transition timestamps.
// i_in carries one transition per beat (time_req, last = track end);
// o_out carries compensated transitions (time_res, last_res).
// Both channels move a beat on a clock edge with valid and ready high.
// i_cfg_we/i_cfg_wdata write the 16-bit push threshold; write it only
// while nothing is in flight.
// Each transition is released by the next one of its track and then
// passes queue, compute pipeline and output register; a track end
// also releases itself. Throughput is one input beat per cycle while
// the queue is not full; an item that closes a track of two or more
// transitions gives two output beats and holds the compute pipeline
// while the second beat goes out. The pipeline depth is set by the
// divide-by-three chain, 16 bits per stage.
// A four-entry queue sits between front and compute pipeline; when the
// receiver stalls, the pipeline holds and i_in.ready falls once the
// queue is full. Synchronous reset empties queue and pipeline, starts a
// new track and clears the threshold to zero.
`timescale 1ns / 1ps

module flux_peak_shift_postcomp #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fpsp_pkg::THR_W-1:0]  i_cfg_wdata,
    fpsp_in_if.sink                     i_in,
    fpsp_out_if.source                  o_out
);
    import fpsp_pkg::*;

    localparam int EW = $bits(t_ctl) + 4 * TIME_WIDTH;

    logic                  c_full;
    logic                  c_empty;
    logic                  c_push;
    logic                  c_pop;
    t_ctl                  c_ctl;
    logic [TIME_WIDTH-1:0] c_t1;
    logic [TIME_WIDTH-1:0] c_t2;
    logic [TIME_WIDTH-1:0] c_g01;
    logic [TIME_WIDTH-1:0] c_g12;
    logic [EW-1:0]         c_wdata;
    logic [EW-1:0]         c_rdata;

    assign c_wdata = {c_ctl, c_t1, c_t2, c_g01, c_g12};

    fpsp_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_time_req (i_in.time_req),
        .i_last     (i_in.last),
        .i_full     (c_full),
        .o_push     (c_push),
        .o_ctl      (c_ctl),
        .o_t1       (c_t1),
        .o_t2       (c_t2),
        .o_g01      (c_g01),
        .o_g12      (c_g12)
    );

    fpsp_fifo #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_push),
        .i_data  (c_wdata),
        .i_pop   (c_pop),
        .o_data  (c_rdata),
        .o_empty (c_empty),
        .o_full  (c_full)
    );

    fpsp_back #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_data      (c_rdata),
        .i_empty     (c_empty),
        .o_pop       (c_pop),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_time_res  (o_out.time_res),
        .o_last_res  (o_out.last_res)
    );

endmodule

// ----- test/tb_flux_peak_shift_postcomp.sv -----
`timescale 1ns / 1ps

module tb_flux_peak_shift_postcomp;
    import fpsp_pkg::*;

    localparam int LATENCY_WAIT = 16;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_BEATS  = 125;
    localparam int N_PHASES     = 5;
    localparam int N_ROWS       = 28;

    typedef struct packed {
        logic [OUT_W-1:0] stamp;
        logic             tail;
    } t_flux_beat;

    typedef enum logic {
        ROW_BEAT,
        ROW_CFG
    } t_row_op;

    typedef struct packed {
        t_row_op          op;
        logic [IN_W-1:0]  stamp;
        logic             tail;
        logic [THR_W-1:0] thr;
        logic             pinned;
        logic [1:0]       n_pin;
        t_flux_beat       pin0;
        t_flux_beat       pin1;
    } t_stim_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [THR_W-1:0] i_cfg_wdata;

    fpsp_in_if  in_if ();
    fpsp_out_if out_if ();

    flux_peak_shift_postcomp DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // track state of the compensator as predicted
    logic [THR_W-1:0] thr_q;
    logic [IN_W-1:0]  prior_stamp;
    logic [IN_W-1:0]  held_stamp;
    t_seen            seen_q;
    t_flux_beat       pending_results[$];

    int unsigned err_count   = 0;
    int unsigned beats_in    = 0;
    int unsigned beats_out   = 0;
    int unsigned idle_cycles = 0;
    int unsigned thr_writes  = 0;
    bit          tx_calm     = 1'b0;
    bit          rx_calm     = 1'b0;
    bit          rx_hold_due = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [OUT_W-1:0] shifted_stamp(input logic [IN_W-1:0] t0,
                                                       input logic [IN_W-1:0] t1,
                                                       input logic [IN_W-1:0] t2);
        logic signed [IN_W-1:0] g01;
        logic signed [IN_W-1:0] g12;
        longint push01;
        longint push12;
        longint shift;
        longint lo;
        longint hi;
        g01    = t1 - t0;
        g12    = t2 - t1;
        push01 = longint'(thr_q) - longint'(g01);
        push12 = longint'(thr_q) - longint'(g12);
        if (push01 < 0) push01 = 0;
        if (push12 < 0) push12 = 0;
        shift = ((push12 - push01) * 5) / 12;
        lo    = -(longint'(g01) / 2);
        hi    = longint'(g12) / 2;
        if (shift < lo) shift = lo;
        if (shift > hi) shift = hi;
        return t1 + shift[IN_W-1:0];
    endfunction

    function automatic int unsigned track_step(input logic [IN_W-1:0] t, input logic l,
                                               output t_flux_beat r0, output t_flux_beat r1);
        t_flux_beat  res [2];
        int unsigned n;
        n      = 0;
        res[0] = '0;
        res[1] = '0;
        case (seen_q)
            S_EMPTY: begin
                held_stamp = t;
                seen_q     = S_ONE;
            end
            S_ONE: begin
                res[0]      = '{held_stamp, 1'b0};
                n           = 1;
                prior_stamp = held_stamp;
                held_stamp  = t;
                seen_q      = S_TWO;
            end
            default: begin
                res[0]      = '{shifted_stamp(prior_stamp, held_stamp, t), 1'b0};
                n           = 1;
                prior_stamp = held_stamp;
                held_stamp  = t;
            end
        endcase
        if (l) begin
            res[n] = '{t, 1'b1};
            n++;
            seen_q = S_EMPTY;
        end
        r0 = res[0];
        r1 = res[1];
        return n;
    endfunction

    function automatic t_stim_row beat(input logic [IN_W-1:0] t, input logic l);
        return '{ROW_BEAT, t, l, '0, 1'b0, 2'd0, '0, '0};
    endfunction

    function automatic t_stim_row pin(input logic [IN_W-1:0] t, input logic l,
                                      input logic [1:0] n,
                                      input logic [OUT_W-1:0] s0, input logic l0,
                                      input logic [OUT_W-1:0] s1, input logic l1);
        return '{ROW_BEAT, t, l, '0, 1'b1, n, '{s0, l0}, '{s1, l1}};
    endfunction

    function automatic t_stim_row thr_row(input logic [THR_W-1:0] v);
        return '{ROW_CFG, '0, 1'b0, v, 1'b0, 2'd0, '0, '0};
    endfunction

    function automatic int unsigned idle_draw(input bit calm);
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [IN_W-1:0] next_gap(input int unsigned span);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) return $urandom_range(0, 2 * span);
        if (pick < 77) return -$urandom_range(0, span);
        if (pick < 85) return thr_q + $urandom_range(0, 2) - 1;
        if (pick < 92) return 32'h8000_0000 + $urandom_range(0, 4) - 2;
        return $urandom;
    endfunction

    task automatic check_result(input logic [OUT_W-1:0] stamp, input logic tail);
        t_flux_beat want;
        beats_out++;
        if (pending_results.size() == 0) begin
            err_count++;
            $display("%0t: unexpected beat, time_res=%08h last_res=%0b", $time, stamp, tail);
            return;
        end
        want = pending_results.pop_front();
        if (stamp !== want.stamp) begin
            err_count++;
            $display("%0t: time_res expected %08h actual %08h", $time, want.stamp, stamp);
        end
        if (tail !== want.tail) begin
            err_count++;
            $display("%0t: last_res expected %0b actual %0b", $time, want.tail, tail);
        end
    endtask

    task automatic send_item(input t_stim_row row);
        t_flux_beat  r0;
        t_flux_beat  r1;
        int unsigned n;
        int unsigned gap;
        gap = idle_draw(tx_calm);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.time_req <= row.stamp;
        in_if.last     <= row.tail;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        beats_in++;
        n = track_step(row.stamp, row.tail, r0, r1);
        if (row.pinned) begin
            n  = row.n_pin;
            r0 = row.pin0;
            r1 = row.pin1;
        end
        if (n > 0) pending_results.push_back(r0);
        if (n > 1) pending_results.push_back(r1);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (LATENCY_WAIT) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] v);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        thr_q = v;
        thr_writes++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            check_result(out_if.time_res, out_if.last_res);
        end
    end

    initial begin
        wait (i_rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("%0t: no beat moved for %0d cycles, %0d results still due",
                 $time, STALL_LIMIT, pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side
    initial begin
        int unsigned hold;
        int unsigned rx_count;
        rx_count     = 0;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (rx_hold_due) begin
                hold        = LONG_HOLD;
                rx_hold_due = 1'b0;
            end else begin
                hold = idle_draw(rx_calm);
            end
            if (hold > 0) begin
                out_if.ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            rx_count++;
            if (rx_count % 32 == 0) rx_calm = ($urandom_range(0, 2) == 0);
            @(negedge i_clk);
        end
    end

    initial begin
        t_stim_row       dir_rows [N_ROWS];
        t_stim_row       row;
        logic [IN_W-1:0] stamp;
        int unsigned     phase_thr [N_PHASES];
        int unsigned     sent;
        int unsigned     len;
        int unsigned     span;
        int unsigned     pick;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        in_if.valid    = 1'b0;
        in_if.time_req = '0;
        in_if.last     = 1'b0;
        thr_q          = '0;
        prior_stamp    = '0;
        held_stamp     = '0;
        seen_q         = S_EMPTY;

        dir_rows = '{
            // zero threshold after reset, short tracks pass through
            pin(32'h0000_0000, 1'b1, 2'd1, 32'h0000_0000, 1'b1, '0, 1'b0),
            pin(32'hFFFF_FFFF, 1'b1, 2'd1, 32'hFFFF_FFFF, 1'b1, '0, 1'b0),
            pin(32'd100, 1'b0, 2'd0, '0, 1'b0, '0, 1'b0),
            pin(32'd200, 1'b1, 2'd2, 32'd100, 1'b0, 32'd200, 1'b1),
            // times out of order with zero threshold
            pin(32'd1000, 1'b0, 2'd0, '0, 1'b0, '0, 1'b0),
            pin(32'd900, 1'b0, 2'd1, 32'd1000, 1'b0, '0, 1'b0),
            beat(32'd1100, 1'b1),
            thr_row(16'hFFFF),
            pin(32'd0, 1'b0, 2'd0, '0, 1'b0, '0, 1'b0),
            pin(32'd10, 1'b0, 2'd1, 32'd0, 1'b0, '0, 1'b0),
            beat(32'd20, 1'b0),
            beat(32'd5000, 1'b0),
            // half-range gap, then wrap around zero
            beat(32'h8000_1388, 1'b0),
            beat(32'hFFFF_FFF0, 1'b0),
            beat(32'h0000_0010, 1'b0),
            beat(32'h7FFF_FFF0, 1'b0),
            beat(32'hFFFF_FFFF, 1'b1),
            thr_row(16'd1),
            pin(32'hFFFF_FFFE, 1'b0, 2'd0, '0, 1'b0, '0, 1'b0),
            pin(32'd3, 1'b0, 2'd1, 32'hFFFF_FFFE, 1'b0, '0, 1'b0),
            beat(32'd4, 1'b0),
            beat(32'd4, 1'b1),
            thr_row(16'h1234),
            pin(32'd50, 1'b0, 2'd0, '0, 1'b0, '0, 1'b0),
            pin(32'd60, 1'b1, 2'd2, 32'd50, 1'b0, 32'd60, 1'b1),
            beat(32'hA5A5_5A5A, 1'b0),
            beat(32'hA5A5_5B00, 1'b0),
            beat(32'hA5A5_6000, 1'b1)
        };

        phase_thr = '{32'hFFFF, 0, $urandom_range(0, 65535), $urandom_range(1, 64), 32'h8000};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_CFG) begin
                write_threshold(dir_rows[i].thr);
            end else begin
                send_item(dir_rows[i]);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_threshold(phase_thr[p][THR_W-1:0]);
            sent = 0;
            while (sent < PHASE_BEATS) begin
                pick  = $urandom_range(0, 99);
                len   = (pick < 15) ? $urandom_range(1, 2) :
                        (pick < 85) ? $urandom_range(3, 12) : $urandom_range(13, 40);
                stamp = $urandom;
                span  = (thr_q < 32) ? 32 : thr_q;
                for (int k = 0; k < len; k++) begin
                    if (k > 0) stamp = stamp + next_gap(span);
                    row = beat(stamp, k == len - 1);
                    if (sent % 32 == 0) tx_calm = ($urandom_range(0, 2) == 0);
                    // long output stall with the input kept busy
                    if (p == 1 && sent == 40) begin
                        rx_hold_due = 1'b1;
                        tx_calm     = 1'b1;
                    end
                    if (p == 2 && sent == 60) drain_results();
                    send_item(row);
                    sent++;
                end
            end
        end

        drain_results();
        $display("%0d transitions sent over %0d threshold settings, %0d result beats checked",
                 beats_in, thr_writes, beats_out);
        $display("tracks of one to forty transitions, wrapped and reversed times, stalls");
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
